>>> rtl/ddac_pkg.sv
// ----------------------------------------------------------------------------
// ddac_pkg
// Shared constants, types and codes of the dual-axis deadband controller.
// ----------------------------------------------------------------------------
package ddac_pkg;

  // Samples averaged per block and width of one converter sample.
  localparam int unsigned FilterTaps = 8;
  localparam int unsigned SampleBits = 12;

  // Width of the configuration registers and of the reported averages.
  localparam int unsigned RegBits = 12;

  // Running and held sums; also wide enough for a setpoint scaled by FilterTaps.
  localparam int unsigned SumBits =
      $clog2(FilterTaps * ((2 ** SampleBits) - 1) + 1) >
      $clog2(FilterTaps * ((2 ** RegBits) - 1) + 1)
      ? $clog2(FilterTaps * ((2 ** SampleBits) - 1) + 1)
      : $clog2(FilterTaps * ((2 ** RegBits) - 1) + 1);

  // Sample counter holds 0..FilterTaps.
  localparam int unsigned CountBits = $clog2(FilterTaps + 1);

  // Configuration port.
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = RegBits;

  localparam logic [CfgIdxBits-1:0] CfgSetpointAxis1 = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgSetpointAxis2 = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgDeadband      = 2'd2;

  localparam logic [RegBits-1:0] SetpointAxis1Rst = 12'd2350;
  localparam logic [RegBits-1:0] SetpointAxis2Rst = 12'd2300;
  localparam logic [RegBits-1:0] DeadbandRst      = 12'd20;

  typedef enum logic [1:0] {
    DriveHold    = 2'd0,
    DriveExtend  = 2'd1,
    DriveRetract = 2'd2
  } drive_e;

  // Status of the block averager as seen by the control stage.
  typedef struct packed {
    logic [SumBits-1:0] held_sum_axis1;
    logic [SumBits-1:0] held_sum_axis2;
    logic               block_full;
  } acc_status_t;

endpackage

>>> rtl/ddac_if.sv
// ----------------------------------------------------------------------------
// ddac_in_if / ddac_out_if
// Valid/ready channels carrying sample items in and drive results out.
// ----------------------------------------------------------------------------
interface ddac_in_if;
  logic                             valid;
  logic                             ready;
  logic [ddac_pkg::SampleBits-1:0]  sample_axis1;
  logic [ddac_pkg::SampleBits-1:0]  sample_axis2;
  logic                             mode_active;

  modport source (output valid, output sample_axis1, output sample_axis2,
                  output mode_active, input ready);
  modport sink   (input valid, input sample_axis1, input sample_axis2,
                  input mode_active, output ready);
endinterface

interface ddac_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    drive_axis1;
  logic [1:0]                    drive_axis2;
  logic [ddac_pkg::RegBits-1:0]  average_axis1;
  logic [ddac_pkg::RegBits-1:0]  average_axis2;
  logic                          average_updated;

  modport source (output valid, output drive_axis1, output drive_axis2,
                  output average_axis1, output average_axis2,
                  output average_updated, input ready);
  modport sink   (input valid, input drive_axis1, input drive_axis2,
                  input average_axis1, input average_axis2,
                  input average_updated, output ready);
endinterface

>>> rtl/ddac_accum.sv
// ----------------------------------------------------------------------------
// ddac_accum
// Block averager: sums samples per axis and latches completed block sums.
// ----------------------------------------------------------------------------
module ddac_accum (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [ddac_pkg::SampleBits-1:0] sample_axis1_i,
  input  logic [ddac_pkg::SampleBits-1:0] sample_axis2_i,
  output ddac_pkg::acc_status_t           status_o
);
  import ddac_pkg::*;

  logic [SumBits-1:0]   run1_q, run1_d;
  logic [SumBits-1:0]   run2_q, run2_d;
  logic [SumBits-1:0]   held1_q, held1_d;
  logic [SumBits-1:0]   held2_q, held2_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 full;

  assign full = (count_q == CountBits'(FilterTaps));

  // On the tick after a full block the sums are latched and this tick's
  // samples are dropped.
  always_comb begin
    run1_d  = run1_q;
    run2_d  = run2_q;
    held1_d = held1_q;
    held2_d = held2_q;
    count_d = count_q;
    if (step_i) begin
      if (full) begin
        held1_d = run1_q;
        held2_d = run2_q;
        run1_d  = '0;
        run2_d  = '0;
        count_d = '0;
      end else begin
        run1_d  = run1_q + SumBits'(sample_axis1_i);
        run2_d  = run2_q + SumBits'(sample_axis2_i);
        count_d = count_q + CountBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run1_q  <= '0;
      run2_q  <= '0;
      held1_q <= '0;
      held2_q <= '0;
      count_q <= '0;
    end else begin
      run1_q  <= run1_d;
      run2_q  <= run2_d;
      held1_q <= held1_d;
      held2_q <= held2_d;
      count_q <= count_d;
    end
  end

  assign status_o.held_sum_axis1 = held1_q;
  assign status_o.held_sum_axis2 = held2_q;
  assign status_o.block_full     = full;

endmodule

>>> rtl/ddac_axis_cmp.sv
// ----------------------------------------------------------------------------
// ddac_axis_cmp
// Per-axis bang-bang decision with deadband against the held block sum.
// ----------------------------------------------------------------------------
module ddac_axis_cmp (
  input  logic [ddac_pkg::RegBits-1:0] setpoint_i,
  input  logic [ddac_pkg::RegBits-1:0] deadband_i,
  input  logic [ddac_pkg::SumBits-1:0] held_sum_i,
  input  logic                         active_i,
  output ddac_pkg::drive_e             drive_o
);
  import ddac_pkg::*;

  logic [SumBits-1:0] target;
  logic [SumBits-1:0] band;
  logic [SumBits-1:0] err;
  logic               above;

  // Scaling by the tap count keeps the comparison exact without a divide.
  assign target = SumBits'(setpoint_i) * SumBits'(FilterTaps);
  assign band   = SumBits'(deadband_i) * SumBits'(FilterTaps);
  assign above  = target > held_sum_i;
  assign err    = above ? (target - held_sum_i) : (held_sum_i - target);

  always_comb begin
    drive_o = DriveHold;
    if (active_i && (err > band)) begin
      drive_o = above ? DriveExtend : DriveRetract;
    end
  end

endmodule

>>> rtl/dual_axis_deadband_actuator_ctrl_unit.sv
// ----------------------------------------------------------------------------
// dual_axis_deadband_actuator_ctrl_unit
// Two-axis bang-bang position controller with block averaging and deadband.
// ----------------------------------------------------------------------------
// Usage: every control tick, send one transaction on in_chan with a position
// sample per axis and the mode flag. Each input transaction yields exactly one
// output transaction on out_chan with the two drive commands (hold, extend,
// retract), the last completed block averages and a flag marking the tick on
// which a new block average was latched.
// The input stage holds the block averager update and the captured mode flag;
// the output register then holds the drive decisions. Throughput is one
// transaction per cycle while out_chan.ready is high; the critical path is
// the setpoint scaling, the error subtract and the deadband compare.
// Setpoints and deadband must be written via cfg only while no transaction is
// in flight; the block does not enforce this. Reset restores the default
// setpoints and deadband, clears all sums and the sample count, and empties
// both stages. When the receiver stalls, the result stays in the output
// register, one more item may sit in the input stage, and then in_chan.ready
// drops until the output transaction completes.
// ----------------------------------------------------------------------------
module dual_axis_deadband_actuator_ctrl_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ddac_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [ddac_pkg::CfgDataBits-1:0] cfg_data_i,
  ddac_in_if.sink                          in_chan,
  ddac_out_if.source                       out_chan
);
  import ddac_pkg::*;

  // Configuration registers.
  logic [RegBits-1:0] setpoint1_q;
  logic [RegBits-1:0] setpoint2_q;
  logic [RegBits-1:0] deadband_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint1_q <= SetpointAxis1Rst;
      setpoint2_q <= SetpointAxis2Rst;
      deadband_q  <= DeadbandRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSetpointAxis1: setpoint1_q <= cfg_data_i;
        CfgSetpointAxis2: setpoint2_q <= cfg_data_i;
        CfgDeadband:      deadband_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake. The input stage advances whenever it is empty or the output register
  // is free or is being emptied this cycle.
  logic s1_valid_q;
  logic s1_mode_q;
  logic s1_upd_q;
  logic out_free;
  logic s1_free;
  logic in_take;

  assign out_free     = !out_chan.valid || out_chan.ready;
  assign s1_free      = !s1_valid_q || out_free;
  assign in_chan.ready = s1_free;
  assign in_take      = in_chan.valid && s1_free;

  // Block averager; its held sums belong to the item in the input stage.
  acc_status_t acc_status;

  ddac_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_take),
    .sample_axis1_i (in_chan.sample_axis1),
    .sample_axis2_i (in_chan.sample_axis2),
    .status_o       (acc_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_mode_q <= in_chan.mode_active;
      s1_upd_q  <= acc_status.block_full;
    end
  end

  // Drive decisions for both axes.
  drive_e drive1;
  drive_e drive2;

  ddac_axis_cmp u_cmp_axis1 (
    .setpoint_i (setpoint1_q),
    .deadband_i (deadband_q),
    .held_sum_i (acc_status.held_sum_axis1),
    .active_i   (s1_mode_q),
    .drive_o    (drive1)
  );

  ddac_axis_cmp u_cmp_axis2 (
    .setpoint_i (setpoint2_q),
    .deadband_i (deadband_q),
    .held_sum_i (acc_status.held_sum_axis2),
    .active_i   (s1_mode_q),
    .drive_o    (drive2)
  );

  // Block averages; the divide by the tap count is a constant divide.
  logic [SumBits-1:0] avg1_full;
  logic [SumBits-1:0] avg2_full;

  assign avg1_full = acc_status.held_sum_axis1 / SumBits'(FilterTaps);
  assign avg2_full = acc_status.held_sum_axis2 / SumBits'(FilterTaps);

  // Result register.
  logic               out_valid_q;
  drive_e             drive1_q;
  drive_e             drive2_q;
  logic [RegBits-1:0] avg1_q;
  logic [RegBits-1:0] avg2_q;
  logic               upd_q;
  logic               s1_move;

  assign s1_move = s1_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      drive1_q <= drive1;
      drive2_q <= drive2;
      avg1_q   <= avg1_full[RegBits-1:0];
      avg2_q   <= avg2_full[RegBits-1:0];
      upd_q    <= s1_upd_q;
    end
  end

  assign out_chan.valid           = out_valid_q;
  assign out_chan.drive_axis1     = drive1_q;
  assign out_chan.drive_axis2     = drive2_q;
  assign out_chan.average_axis1   = avg1_q;
  assign out_chan.average_axis2   = avg2_q;
  assign out_chan.average_updated = upd_q;

endmodule
